// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker module of the blending core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and held off while rst_n is low.
`define AP_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk and held off while rst_n is low.
`define AP_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- rtl/abp_pkg.sv -----
// Package with the types, constants and fixed-point helpers of the blending core.
`default_nettype none

package abp_pkg;

    localparam int CHAN_W  = 8;
    localparam int GA_W    = 9;
    localparam int WGT_W   = 16;
    localparam int PROD_W  = CHAN_W + WGT_W;
    localparam int LANES   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = GA_W;

    localparam logic [GA_W-1:0]   GA_MAX      = 9'd256;
    localparam logic [WGT_W-1:0]  FULL_WEIGHT = 16'd65280;
    localparam logic [CHAN_W-1:0] CHAN_MAX    = 8'd255;

    // Channel order inside a pixel.
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;
    localparam int CH_ALPHA = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLOBAL_ALPHA  = 2'd0,
        CFG_PREMULTIPLIED = 2'd1
    } cfg_reg_t;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [WGT_W-1:0]  weight_t;
    typedef logic [PROD_W-1:0] prod_t;

    // Control that travels alongside the lane data.
    typedef struct packed {
        logic valid;
        logic keep_bg;
    } ctrl_t;

    // What one lane hands to the merge stage.
    typedef struct packed {
        chan_t blend;
        chan_t bg;
    } lane_out_t;

    // Floor of x / 65280 for x up to 255 * 65280. The division by 256 is a
    // shift; the division by 255 is an estimate that is never high and at
    // most one low, fixed by a single compare and increment.
    function automatic logic [8:0] div_full_weight(input prod_t x);
        logic [15:0] y;
        logic [16:0] s;
        logic [8:0]  q;
        logic [16:0] qx255;
        logic [16:0] r;
        y     = x[PROD_W-1:8];
        s     = {1'b0, y} + {9'b0, y[15:8]};
        q     = s[16:8];
        qx255 = {q, 8'b0} - {8'b0, q};
        r     = {1'b0, y} - qx255;
        if (r >= 17'd255)
        begin
            q = q + 9'd1;
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/abp_lane.sv -----
// One color lane: weight products, then the constant division, sum and saturation.
`default_nettype none

module abp_lane
    import abp_pkg::*;
(
    input  wire logic      clk,
    input  wire chan_t     fg,
    input  wire chan_t     bg,
    input  wire weight_t   w,
    input  wire logic      pre,
    output lane_out_t      lane_out
);

    prod_t fg_prod_reg;
    prod_t bg_prod_reg;
    chan_t fg_reg;
    chan_t bg_reg;
    logic  pre_reg;

    lane_out_t lane_out_reg;
    lane_out_t lane_out_next;

    logic [8:0] fg_part;
    logic [8:0] bg_part;
    logic [9:0] sum;

    always_ff @(posedge clk)
    begin
        fg_prod_reg <= prod_t'(fg) * prod_t'(w);
        bg_prod_reg <= prod_t'(bg) * prod_t'(FULL_WEIGHT - w);
        fg_reg      <= fg;
        bg_reg      <= bg;
        pre_reg     <= pre;
    end

    always_comb
    begin
        bg_part = div_full_weight(bg_prod_reg);
        fg_part = pre_reg ? {1'b0, fg_reg} : div_full_weight(fg_prod_reg);
        sum     = {1'b0, fg_part} + {1'b0, bg_part};
        lane_out_next.blend = (sum > 10'(CHAN_MAX)) ? CHAN_MAX : sum[CHAN_W-1:0];
        lane_out_next.bg    = bg_reg;
    end

    always_ff @(posedge clk)
    begin
        lane_out_reg <= lane_out_next;
    end

    assign lane_out = lane_out_reg;

endmodule

`default_nettype wire

// ----- rtl/abp_merge.sv -----
// Merge stage: gathers the four lanes into the result beat and picks the background pass-through.
`default_nettype none

module abp_merge
    import abp_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire ctrl_t     ctrl,
    input  wire lane_out_t lanes [LANES],
    output logic           out_valid,
    output chan_t          out_red,
    output chan_t          out_green,
    output chan_t          out_blue,
    output chan_t          out_alpha,
    output logic           write_enable
);

    logic  out_valid_reg;
    chan_t chan_reg [LANES];
    logic  write_enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= ctrl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            chan_reg[i] <= ctrl.keep_bg ? lanes[i].bg : lanes[i].blend;
        end
        write_enable_reg <= !ctrl.keep_bg;
    end

    assign out_valid    = out_valid_reg;
    assign out_red      = chan_reg[CH_RED];
    assign out_green    = chan_reg[CH_GREEN];
    assign out_blue     = chan_reg[CH_BLUE];
    assign out_alpha    = chan_reg[CH_ALPHA];
    assign write_enable = write_enable_reg;

endmodule

`default_nettype wire

// ----- rtl/alpha_blend_pixel_core.sv -----
// Top level of the RGBA8 over-blending core: config registers, weight stage, lanes and merge.
//
//   Channel     Direction  Handshake               Payload
//   ---------   ---------  ----------------------  --------------------------------------
//   command     in         start high, busy low    fg_red..fg_alpha, bg_red..bg_alpha
//   result      out        out_valid strobe        out_red..out_alpha, write_enable
//   config      in         cfg_valid and cfg_ready cfg_index, cfg_data
//
// One pixel beat is accepted every clock cycle; busy never rises. Each beat
// passes, in order, through the weight multiply, the per-lane products, the
// division by 65280 and saturation, and the merge register. The receiver
// cannot stall, so the pipeline never holds. Reset clears the valid flags
// of every stage and restores global_alpha to 256 and premultiplied to 0.
`default_nettype none

module alpha_blend_pixel_core
    import abp_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  start,
    output logic                       busy,
    input  wire chan_t                 fg_red,
    input  wire chan_t                 fg_green,
    input  wire chan_t                 fg_blue,
    input  wire chan_t                 fg_alpha,
    input  wire chan_t                 bg_red,
    input  wire chan_t                 bg_green,
    input  wire chan_t                 bg_blue,
    input  wire chan_t                 bg_alpha,

    output logic                       out_valid,
    output chan_t                      out_red,
    output chan_t                      out_green,
    output chan_t                      out_blue,
    output chan_t                      out_alpha,
    output logic                       write_enable,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // The pipeline takes a beat every cycle, and registers can always be written.
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    logic accept;
    assign accept = start && !busy;

    // Configuration registers.
    logic [GA_W-1:0] global_alpha_reg;
    logic            premultiplied_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            global_alpha_reg  <= GA_MAX;
            premultiplied_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_GLOBAL_ALPHA:  global_alpha_reg  <= cfg_data[GA_W-1:0];
                CFG_PREMULTIPLIED: premultiplied_reg <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // Any global alpha of 256 or more means fully opaque, so bit 8 alone
    // decides the saturation.
    logic [GA_W-1:0] ga_sat;
    logic [16:0]     w_full;
    assign ga_sat = global_alpha_reg[GA_W-1] ? GA_MAX : global_alpha_reg;
    assign w_full = 17'(fg_alpha) * 17'(ga_sat);

    // Stage 1: capture the pixel pair and the shared pixel weight. The weight
    // never exceeds 255 * 256, so 16 bits hold it.
    ctrl_t   s1_ctrl_reg;
    ctrl_t   s2_ctrl_reg;
    ctrl_t   s3_ctrl_reg;
    chan_t   s1_fg_reg [LANES];
    chan_t   s1_bg_reg [LANES];
    weight_t s1_w_reg;
    logic    s1_pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctrl_reg <= '0;
            s2_ctrl_reg <= '0;
            s3_ctrl_reg <= '0;
        end
        else
        begin
            s1_ctrl_reg.valid   <= accept;
            s1_ctrl_reg.keep_bg <= (fg_alpha == '0);
            s2_ctrl_reg         <= s1_ctrl_reg;
            s3_ctrl_reg         <= s2_ctrl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_fg_reg[CH_RED]   <= fg_red;
        s1_fg_reg[CH_GREEN] <= fg_green;
        s1_fg_reg[CH_BLUE]  <= fg_blue;
        s1_fg_reg[CH_ALPHA] <= fg_alpha;
        s1_bg_reg[CH_RED]   <= bg_red;
        s1_bg_reg[CH_GREEN] <= bg_green;
        s1_bg_reg[CH_BLUE]  <= bg_blue;
        s1_bg_reg[CH_ALPHA] <= bg_alpha;
        s1_w_reg            <= w_full[WGT_W-1:0];
        s1_pre_reg          <= premultiplied_reg;
    end

    // Stages 2 and 3: one lane per channel, alpha treated like a color.
    lane_out_t lanes [LANES];

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        abp_lane u_lane (
            .clk      (clk),
            .fg       (s1_fg_reg[g]),
            .bg       (s1_bg_reg[g]),
            .w        (s1_w_reg),
            .pre      (s1_pre_reg),
            .lane_out (lanes[g])
        );
    end

    // Stage 4: the merge register chooses blended or untouched background.
    abp_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (s3_ctrl_reg),
        .lanes        (lanes),
        .out_valid    (out_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .write_enable (write_enable)
    );

endmodule

`default_nettype wire

// ----- rtl/abp_checker.sv -----
// Port-level checker for the blending core, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module abp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [7:0] fg_alpha,
    input wire logic [7:0] bg_red,
    input wire logic [7:0] bg_alpha,
    input wire logic       out_valid,
    input wire logic [7:0] out_red,
    input wire logic [7:0] out_alpha,
    input wire logic       write_enable
);

    // Every accepted beat yields exactly one result.
    `AP_IMPLY(a_latency, start && !busy, ##4 out_valid)
    `AP_IMPLY(a_no_phantom, out_valid, $past(start && !busy, 4))

    // A transparent foreground hands back the background untouched.
    `AP_IMPLY(a_keep_bg, out_valid && !write_enable, out_red == $past(bg_red, 4) && out_alpha == $past(bg_alpha, 4))

    // The write flag drops only for a foreground alpha of zero.
    `AP_IMPLY(a_we_alpha, out_valid, write_enable == ($past(fg_alpha, 4) != 8'd0))

endmodule

bind alpha_blend_pixel_core abp_checker u_abp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .fg_alpha     (fg_alpha),
    .bg_red       (bg_red),
    .bg_alpha     (bg_alpha),
    .out_valid    (out_valid),
    .out_red      (out_red),
    .out_alpha    (out_alpha),
    .write_enable (write_enable)
);

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for the RGBA8 over-blending core alpha_blend_pixel_core.
module testbench
    import abp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // Register indexes that map to nothing; a write to them must leave the
    // blending setup untouched.
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED_HI = 2'd3;

    // The drain at the end waits longer than a beat takes to pass the pipeline,
    // so that a stray late result is still caught.
    localparam int DRAIN_CYCLES   = 8;
    localparam int PRINT_LIMIT    = 40;
    localparam int RANDOM_PHASES  = 14;
    localparam int PHASE_PIXELS   = 49;

    typedef struct packed {
        chan_t [LANES-1:0] fg;
        chan_t [LANES-1:0] bg;
    } pixel_t;

    typedef struct packed {
        chan_t [LANES-1:0] chan;
        logic              wen;
    } blend_result_t;

    typedef enum logic {
        ITEM_PIXEL,
        ITEM_REG_WRITE
    } item_kind_t;

    // One entry of the stimulus list: either a pixel beat or a register
    // write, with the number of idle cycles that goes ahead of it.
    typedef struct packed {
        item_kind_t              kind;
        int unsigned             gap;
        pixel_t                  px;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_data;
    } stim_item_t;

    logic                  clk;
    logic                  rst_n;

    logic                  start = 1'b0;
    logic                  busy;
    chan_t                 fg_red = '0;
    chan_t                 fg_green = '0;
    chan_t                 fg_blue = '0;
    chan_t                 fg_alpha = '0;
    chan_t                 bg_red = '0;
    chan_t                 bg_green = '0;
    chan_t                 bg_blue = '0;
    chan_t                 bg_alpha = '0;

    logic                  out_valid;
    chan_t                 out_red;
    chan_t                 out_green;
    chan_t                 out_blue;
    chan_t                 out_alpha;
    logic                  write_enable;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Stimulus waiting to be driven, and blended pixels predicted for beats
    // that were accepted but whose result has not shown up yet.
    stim_item_t            pending_items[$];
    blend_result_t         blend_expect[$];

    // Private copy of the two configuration registers, updated at the edge
    // that accepts each write.
    logic [GA_W-1:0]       ga_model;
    logic                  pre_model;

    int unsigned           mismatch_count = 0;
    int unsigned           gap_left;
    logic                  gap_loaded;

    string                 lane_name[LANES] = '{"red", "green", "blue", "alpha"};

    alpha_blend_pixel_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .fg_red       (fg_red),
        .fg_green     (fg_green),
        .fg_blue      (fg_blue),
        .fg_alpha     (fg_alpha),
        .bg_red       (bg_red),
        .bg_green     (bg_green),
        .bg_blue      (bg_blue),
        .bg_alpha     (bg_alpha),
        .out_valid    (out_valid),
        .out_red      (out_red),
        .out_green    (out_green),
        .out_blue     (out_blue),
        .out_alpha    (out_alpha),
        .write_enable (write_enable),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Prints one line per mismatch (up to a cap, so a badly broken design
    // does not flood the log) and counts every one of them.
    task automatic flag_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
        begin
            $display("MISMATCH at %0t ns: %s", $time, what);
        end
        mismatch_count++;
    endtask

    // Blended pixel that the core must return for one beat under the
    // current register setup. The weight numerator is fg_alpha times the
    // clamped global alpha, so it spans 0 to 65280 and both quotients are
    // exact integer floors.
    function automatic blend_result_t blend_expected(input pixel_t px);
        blend_result_t res;
        int unsigned   ga_eff;
        int unsigned   wgt;
        int unsigned   fg_part;
        int unsigned   bg_part;
        int unsigned   sum;
        if (px.fg[CH_ALPHA] == '0)
        begin
            // A fully transparent foreground leaves the background as it is
            // and tells the frame buffer not to write.
            res.chan = px.bg;
            res.wen  = 1'b0;
            return res;
        end
        ga_eff = (ga_model > GA_MAX) ? int'(GA_MAX) : int'(ga_model);
        wgt    = int'(px.fg[CH_ALPHA]) * ga_eff;
        for (int i = 0; i < LANES; i++)
        begin
            bg_part = (int'(px.bg[i]) * (int'(FULL_WEIGHT) - wgt)) / int'(FULL_WEIGHT);
            fg_part = pre_model ? int'(px.fg[i])
                                : (int'(px.fg[i]) * wgt) / int'(FULL_WEIGHT);
            sum     = fg_part + bg_part;
            res.chan[i] = (sum > int'(CHAN_MAX)) ? CHAN_MAX : chan_t'(sum);
        end
        res.wen = 1'b1;
        return res;
    endfunction

    function automatic pixel_t make_pixel(
        input int fr, input int fgr, input int fb, input int fa,
        input int br, input int bgr, input int bb, input int ba
    );
        pixel_t px;
        px.fg[CH_RED]   = chan_t'(fr);
        px.fg[CH_GREEN] = chan_t'(fgr);
        px.fg[CH_BLUE]  = chan_t'(fb);
        px.fg[CH_ALPHA] = chan_t'(fa);
        px.bg[CH_RED]   = chan_t'(br);
        px.bg[CH_GREEN] = chan_t'(bgr);
        px.bg[CH_BLUE]  = chan_t'(bb);
        px.bg[CH_ALPHA] = chan_t'(ba);
        return px;
    endfunction

    // Channel value that lands on the ends of the range now and then.
    function automatic chan_t pick_chan();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            return 8'd0;
        end
        if (r < 16)
        begin
            return 8'd255;
        end
        return chan_t'($urandom_range(0, 255));
    endfunction

    // Idle cycles ahead of an item: none if not bursty, else mostly none or few,
    // at times a long hole, so gaps land on every stage of the four-deep pipeline.
    function automatic int unsigned pick_gap(input bit bursty);
        int unsigned r;
        if (!bursty)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    task automatic queue_pixel(input pixel_t px, input int unsigned gap);
        stim_item_t item;
        item          = '0;
        item.kind     = ITEM_PIXEL;
        item.gap      = gap;
        item.px       = px;
        pending_items.push_back(item);
    endtask

    task automatic queue_reg_write(
        input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data,
        input int unsigned gap
    );
        stim_item_t item;
        item          = '0;
        item.kind     = ITEM_REG_WRITE;
        item.gap      = gap;
        item.reg_idx  = idx;
        item.reg_data = data;
        pending_items.push_back(item);
    endtask

    // Driver. It predicts each beat at the edge that accepts it, from the
    // very values on the pins, and applies each register write to the
    // private register copy at the edge that accepts it. Register writes
    // are only launched once every predicted pixel has come back, so the
    // pipeline is empty whenever the setup changes. start and cfg_valid get
    // exactly one nonblocking assignment per edge; a start that stays high for a
    // back-to-back beat is simply left high.
    always @(posedge clk or negedge rst_n)
    begin : stim_driver
        stim_item_t item;
        pixel_t     seen;
        logic       pix_live;
        logic       cfg_live;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cfg_valid  <= 1'b0;
            gap_left   = 0;
            gap_loaded = 1'b0;
            ga_model   = GA_MAX;
            pre_model  = 1'b0;
        end
        else
        begin
            pix_live = start;
            cfg_live = cfg_valid;
            if (start && !busy)
            begin
                seen = make_pixel(fg_red, fg_green, fg_blue, fg_alpha,
                                  bg_red, bg_green, bg_blue, bg_alpha);
                blend_expect.push_back(blend_expected(seen));
                pix_live = 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_GLOBAL_ALPHA:  ga_model  = cfg_data;
                    CFG_PREMULTIPLIED: pre_model = cfg_data[0];
                    default:           ;
                endcase
                cfg_live = 1'b0;
            end
            if (!pix_live && !cfg_live && pending_items.size() > 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = pending_items[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (pending_items[0].kind == ITEM_PIXEL)
                begin
                    item       = pending_items.pop_front();
                    gap_loaded = 1'b0;
                    pix_live   = 1'b1;
                    fg_red     <= item.px.fg[CH_RED];
                    fg_green   <= item.px.fg[CH_GREEN];
                    fg_blue    <= item.px.fg[CH_BLUE];
                    fg_alpha   <= item.px.fg[CH_ALPHA];
                    bg_red     <= item.px.bg[CH_RED];
                    bg_green   <= item.px.bg[CH_GREEN];
                    bg_blue    <= item.px.bg[CH_BLUE];
                    bg_alpha   <= item.px.bg[CH_ALPHA];
                end
                else if (blend_expect.size() == 0)
                begin
                    item       = pending_items.pop_front();
                    gap_loaded = 1'b0;
                    cfg_live   = 1'b1;
                    cfg_index  <= item.reg_idx;
                    cfg_data   <= item.reg_data;
                end
            end
            start     <= pix_live;
            cfg_valid <= cfg_live;
        end
    end

    // Monitor. A result is on the pins for exactly one cycle with out_valid
    // high; it is taken at the edge that closes that cycle and checked field
    // by field against the oldest prediction.
    always @(posedge clk)
    begin : result_monitor
        blend_result_t want;
        blend_result_t got;
        if (rst_n)
        begin
            if ($isunknown(out_valid))
            begin
                flag_mismatch("out_valid is unknown");
            end
            else if (out_valid)
            begin
                got.chan[CH_RED]   = out_red;
                got.chan[CH_GREEN] = out_green;
                got.chan[CH_BLUE]  = out_blue;
                got.chan[CH_ALPHA] = out_alpha;
                got.wen            = write_enable;
                if (blend_expect.size() == 0)
                begin
                    flag_mismatch("blended pixel arrived with no beat outstanding");
                end
                else
                begin
                    want = blend_expect.pop_front();
                    for (int i = 0; i < LANES; i++)
                    begin
                        if (got.chan[i] !== want.chan[i])
                        begin
                            flag_mismatch($sformatf("%s channel: got %0d, expected %0d",
                                                    lane_name[i], got.chan[i],
                                                    want.chan[i]));
                        end
                    end
                    if (got.wen !== want.wen)
                    begin
                        flag_mismatch($sformatf("write_enable: got %b, expected %b",
                                                got.wen, want.wen));
                    end
                end
            end
        end
    end

    // Stimulus list and end of run. The directed part runs first, partly
    // under the reset setup, then random phases each start with a fresh
    // register setup and a stream of pixels.
    initial
    begin : stimulus_and_end
        logic [GA_W-1:0] ga_pick;
        logic            pre_bit;
        logic [7:0]      junk;
        bit              bursty;
        pixel_t          px;
        int unsigned     r;

        rst_n = 1'b0;

        // Reset setup: global alpha fully opaque, straight colors.
        queue_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0), 0);
        queue_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255), 0);
        queue_pixel(make_pixel(255, 255, 255, 255, 0, 0, 0, 0), 1);
        // Transparent foreground: the background passes with no write.
        queue_pixel(make_pixel(255, 255, 255, 0, 12, 34, 56, 78), 0);
        queue_pixel(make_pixel(255, 255, 255, 1, 255, 255, 255, 255), 2);
        queue_pixel(make_pixel(200, 100, 50, 128, 10, 20, 30, 40), 0);
        queue_pixel(make_pixel(0, 0, 0, 255, 255, 255, 255, 255), 0);
        queue_pixel(make_pixel(255, 255, 255, 254, 255, 255, 255, 255), 3);

        // Writes to unmapped indexes must not disturb the setup.
        queue_reg_write(CFG_UNMAPPED_LO, 9'h1FF, 0);
        queue_reg_write(CFG_UNMAPPED_HI, 9'h000, 1);
        queue_pixel(make_pixel(255, 255, 255, 128, 0, 0, 0, 0), 0);

        // Zero global alpha with premultiplied colors: fg plus bg, which
        // saturates when the sum runs past 255.
        queue_reg_write(CFG_GLOBAL_ALPHA, 9'd0, 0);
        queue_reg_write(CFG_PREMULTIPLIED, 9'd1, 0);
        queue_pixel(make_pixel(200, 200, 200, 200, 200, 200, 200, 200), 0);
        queue_pixel(make_pixel(0, 0, 0, 1, 0, 0, 0, 0), 0);
        queue_pixel(make_pixel(90, 90, 90, 0, 250, 251, 252, 253), 0);

        // Zero global alpha with straight colors: background kept, write on.
        queue_reg_write(CFG_PREMULTIPLIED, 9'd0, 0);
        queue_pixel(make_pixel(255, 255, 255, 255, 1, 2, 3, 4), 0);

        // Global alpha above 256 clamps to fully opaque.
        queue_reg_write(CFG_GLOBAL_ALPHA, 9'd511, 2);
        queue_pixel(make_pixel(9, 8, 7, 255, 255, 255, 255, 255), 0);
        queue_pixel(make_pixel(170, 60, 240, 100, 30, 220, 5, 99), 0);
        queue_reg_write(CFG_GLOBAL_ALPHA, 9'd257, 0);
        queue_reg_write(CFG_PREMULTIPLIED, 9'd1, 0);
        queue_pixel(make_pixel(255, 255, 255, 255, 255, 255, 255, 255), 0);
        queue_pixel(make_pixel(100, 100, 100, 128, 200, 200, 200, 200), 1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 8)
                0:       ga_pick = GA_MAX;
                1:       ga_pick = 9'd0;
                2:       ga_pick = 9'd1;
                3:       ga_pick = 9'd255;
                4:       ga_pick = 9'd511;
                5:       ga_pick = GA_W'($urandom_range(257, 510));
                default: ga_pick = GA_W'($urandom_range(2, 254));
            endcase
            pre_bit = ph[0];
            // Upper data bits of the premultiplied write are don't-care;
            // every other pair of phases puts noise on them.
            junk    = (ph % 4 < 2) ? 8'h00 : 8'($urandom_range(0, 255));
            bursty  = (ph % 3 != 0);

            if ($urandom_range(0, 1))
            begin
                queue_reg_write(CFG_GLOBAL_ALPHA, ga_pick, pick_gap(bursty));
                queue_reg_write(CFG_PREMULTIPLIED, {junk, pre_bit}, pick_gap(bursty));
            end
            else
            begin
                queue_reg_write(CFG_PREMULTIPLIED, {junk, pre_bit}, pick_gap(bursty));
                queue_reg_write(CFG_GLOBAL_ALPHA, ga_pick, pick_gap(bursty));
            end
            if (ph % 3 == 1)
            begin
                queue_reg_write(($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_LO
                                                             : CFG_UNMAPPED_HI,
                                GA_W'($urandom_range(0, 511)), pick_gap(bursty));
            end

            for (int n = 0; n < PHASE_PIXELS; n++)
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    px.fg[i] = pick_chan();
                    px.bg[i] = pick_chan();
                end
                // Foreground alpha leans toward its special values.
                r = $urandom_range(0, 99);
                if (r < 12)
                begin
                    px.fg[CH_ALPHA] = 8'd0;
                end
                else if (r < 24)
                begin
                    px.fg[CH_ALPHA] = 8'd255;
                end
                else if (r < 30)
                begin
                    px.fg[CH_ALPHA] = 8'($urandom_range(1, 3));
                end
                queue_pixel(px, pick_gap(bursty));
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Sample at the falling edge, where the driver and monitor have
        // settled for the cycle.
        do
        begin
            @(negedge clk);
        end
        while (pending_items.size() > 0 || start || cfg_valid || blend_expect.size() > 0);

        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $display("testbench NOT OK");
        end
        $finish;
    end

    // Watchdog. The slowest legal run is about 750 beats each behind the
    // longest hole, plus pipeline drains around 40 register writes; the
    // timeout allows at least ten times that.
    initial
    begin : watchdog
        #6_000_000;
        $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/abp_pkg.sv
rtl/abp_lane.sv
rtl/abp_merge.sv
rtl/alpha_blend_pixel_core.sv
rtl/abp_checker.sv
dv/testbench.sv
